/* hw/rtl/qslerp_pkg.sv */
// ----------------------------------------------------------------------------
// Quaternion slerp package
// Shared types, fixed-point constants and CORDIC helpers for the slerp pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package qslerp_pkg;

  localparam int CB = 16;
  localparam int FB = 14;
  localparam int IT = 16;
  localparam int STEP_W = $clog2(IT);
  localparam int ROOT_BITS = FB + 1;
  localparam int NUM_BITS = 2 * FB + 1;
  localparam int NUM_W = $clog2(NUM_BITS);

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] GAIN_Q30 = 32'd652032874;

  localparam logic [16:0] PI_Q = 17'(PI_Q30 >> (30 - FB));
  localparam logic [16:0] HALF_PI_Q = 17'(HALF_PI_Q30 >> (30 - FB));
  localparam logic [19:0] GAIN_Q = 20'(GAIN_Q30 >> (30 - FB));
  localparam logic [14:0] ONE_Q = 15'(1 << FB);
  localparam logic [14:0] LOW_SINE_MAX = 15'd16;
  localparam logic [24:0] RATIO_MAX = 25'(1024 << FB);
  localparam logic [16:0] BLEND_ONE = 17'd65536;

  localparam logic [1:0] PATH_FIRST = 2'd0;
  localparam logic [1:0] PATH_MID = 2'd1;
  localparam logic [1:0] PATH_SLERP = 2'd2;

  localparam logic [31:0] ATAN_Q30 [0:15] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF
  };

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [17:0] z;
  } cord_t;

  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][15:0] b;
    logic [16:0]      t;
    logic [3:0][31:0] prod;
    logic [19:0]      c;
    logic             par;
    logic             low;
    logic [28:0]      n;
    logic [14:0]      sh;
    cord_t            vec;
    logic [16:0]      th;
    logic [16:0]      ang_a;
    logic [16:0]      ang_b;
    cord_t            rota;
    cord_t            rotb;
    logic [28:0]      na;
    logic [28:0]      nb;
    logic [14:0]      rma;
    logic [14:0]      rmb;
    logic [28:0]      qa;
    logic [28:0]      qb;
    logic [24:0]      ra;
    logic [24:0]      rb;
    logic [3:0][27:0] ta;
    logic [3:0][27:0] tb;
    logic [3:0][15:0] r;
    logic [1:0]       path;
  } pipe_t;

  function automatic logic signed [17:0] atan_q(logic [STEP_W-1:0] s);
    return 18'(ATAN_Q30[s] >> (30 - FB));
  endfunction

  function automatic cord_t cord_vec(cord_t v, logic [STEP_W-1:0] s);
    cord_t r;
    logic signed [19:0] dx;
    logic signed [19:0] dy;
    dx = v.y >>> s;
    dy = v.x >>> s;
    if (v.y >= 0) begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + atan_q(s);
    end else begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - atan_q(s);
    end
    return r;
  endfunction

  function automatic cord_t cord_rot(cord_t v, logic [STEP_W-1:0] s);
    cord_t r;
    logic signed [19:0] dx;
    logic signed [19:0] dy;
    dx = v.y >>> s;
    dy = v.x >>> s;
    if (v.z >= 0) begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - atan_q(s);
    end else begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + atan_q(s);
    end
    return r;
  endfunction

  function automatic logic [15:0] sat16(logic signed [28:0] v);
    if (v > 29'sd32767) begin
      return 16'h7FFF;
    end else if (v < -29'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/qslerp_root_cell.sv */
// ----------------------------------------------------------------------------
// Square root cell
// Decides one bit of the half-angle sine by a trial square and compare.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_root_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic [3:0]                    bit_idx,
  input  wire logic                          in_vld,
  input  wire qslerp_pkg::pipe_t             d,
  output logic                               out_vld,
  output qslerp_pkg::pipe_t                  q
);
  import qslerp_pkg::*;

  logic       vld_r;
  pipe_t      data_r;
  pipe_t      data_nxt;
  logic [14:0] cand;
  logic [29:0] sq;

  always_comb begin
    data_nxt = d;
    cand = d.sh | (15'd1 << bit_idx);
    sq = {15'b0, cand} * {15'b0, cand};
    if (sq <= {1'b0, d.n}) begin
      data_nxt.sh = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld = vld_r;
  assign q = data_r;

endmodule

`default_nettype wire

/* hw/rtl/qslerp_cordic_cell.sv */
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation, vectoring on the angle lane or rotating both sine lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_cordic_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          rot,
  input  wire logic [qslerp_pkg::STEP_W-1:0] step,
  input  wire logic                          in_vld,
  input  wire qslerp_pkg::pipe_t             d,
  output logic                               out_vld,
  output qslerp_pkg::pipe_t                  q
);
  import qslerp_pkg::*;

  logic  vld_r;
  pipe_t data_r;
  pipe_t data_nxt;

  always_comb begin
    data_nxt = d;
    if (rot) begin
      data_nxt.rota = cord_rot(d.rota, step);
      data_nxt.rotb = cord_rot(d.rotb, step);
    end else begin
      data_nxt.vec = cord_vec(d.vec, step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld = vld_r;
  assign q = data_r;

endmodule

`default_nettype wire

/* hw/rtl/qslerp_div_cell.sv */
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step for both blend ratios.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_div_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic [qslerp_pkg::NUM_W-1:0]  bit_idx,
  input  wire logic                          in_vld,
  input  wire qslerp_pkg::pipe_t             d,
  output logic                               out_vld,
  output qslerp_pkg::pipe_t                  q
);
  import qslerp_pkg::*;

  logic        vld_r;
  pipe_t       data_r;
  pipe_t       data_nxt;
  logic [15:0] rem_a;
  logic [15:0] rem_b;

  always_comb begin
    data_nxt = d;
    rem_a = {d.rma, d.na[bit_idx]};
    rem_b = {d.rmb, d.nb[bit_idx]};
    if (rem_a >= {1'b0, d.sh}) begin
      data_nxt.rma = 15'(rem_a - {1'b0, d.sh});
      data_nxt.qa[bit_idx] = 1'b1;
    end else begin
      data_nxt.rma = rem_a[14:0];
    end
    if (rem_b >= {1'b0, d.sh}) begin
      data_nxt.rmb = 15'(rem_b - {1'b0, d.sh});
      data_nxt.qb[bit_idx] = 1'b1;
    end else begin
      data_nxt.rmb = rem_b[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld = vld_r;
  assign q = data_r;

endmodule

`default_nettype wire

/* hw/rtl/quaternion_slerp.sv */
// ----------------------------------------------------------------------------
// Quaternion slerp
// Fixed-point spherical linear interpolation of two Q2.14 quaternions.
// ----------------------------------------------------------------------------
// A request carries two quaternions and a blend fraction scaled by 65536 on
// the in_ channel; one result with its path code leaves on the out_ channel.
// Both channels move a request when valid is high and stall is low.
// The datapath is a row of cells in a single pipe: 15 square root cells,
// 16 vectoring CORDIC cells, 16 rotation CORDIC cells and 29 divider cells,
// plus eleven stages for products, angles, ratios and the final blend.
// One request is taken every cycle while in_stall is low. The whole pipe
// advances together; while the output register holds a result that the
// receiver stalls, the pipe freezes and in_stall is raised. Reset clears
// the valid bits only; the data registers keep their contents.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_slerp (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_a_w,
  input  wire logic [15:0] in_a_x,
  input  wire logic [15:0] in_a_y,
  input  wire logic [15:0] in_a_z,
  input  wire logic [15:0] in_b_w,
  input  wire logic [15:0] in_b_x,
  input  wire logic [15:0] in_b_y,
  input  wire logic [15:0] in_b_z,
  input  wire logic [17:0] in_blend,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_r_w,
  output logic [15:0]      out_r_x,
  output logic [15:0]      out_r_y,
  output logic [15:0]      out_r_z,
  output logic [1:0]       out_path
);
  import qslerp_pkg::*;

  localparam int NST = 11;

  logic            en;
  pipe_t           st_r   [0:NST-1];
  pipe_t           st_nxt [0:NST-1];
  logic [NST-1:0]  sv_r;
  logic [NST-1:0]  sv_nxt;

  pipe_t           root_d [0:ROOT_BITS];
  logic            root_v [0:ROOT_BITS];
  pipe_t           vec_d  [0:IT];
  logic            vec_v  [0:IT];
  pipe_t           rot_d  [0:IT];
  logic            rot_v  [0:IT];
  pipe_t           div_d  [0:NUM_BITS];
  logic            div_v  [0:NUM_BITS];

  assign en = !(sv_r[NST-1] && out_stall);
  assign in_stall = !en;

  assign root_d[0] = st_r[2];
  assign root_v[0] = sv_r[2];
  assign vec_d[0] = st_r[3];
  assign vec_v[0] = sv_r[3];
  assign rot_d[0] = st_r[6];
  assign rot_v[0] = sv_r[6];
  assign div_d[0] = st_r[7];
  assign div_v[0] = sv_r[7];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
    qslerp_root_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .bit_idx(4'(ROOT_BITS - 1 - k)),
      .in_vld(root_v[k]), .d(root_d[k]),
      .out_vld(root_v[k+1]), .q(root_d[k+1])
    );
  end

  for (genvar k = 0; k < IT; k++) begin : g_vec
    qslerp_cordic_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .rot(1'b0),
      .step(STEP_W'(k)),
      .in_vld(vec_v[k]), .d(vec_d[k]),
      .out_vld(vec_v[k+1]), .q(vec_d[k+1])
    );
  end

  for (genvar k = 0; k < IT; k++) begin : g_rot
    qslerp_cordic_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .rot(1'b1),
      .step(STEP_W'(k)),
      .in_vld(rot_v[k]), .d(rot_d[k]),
      .out_vld(rot_v[k+1]), .q(rot_d[k+1])
    );
  end

  for (genvar k = 0; k < NUM_BITS; k++) begin : g_div
    qslerp_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .bit_idx(NUM_W'(NUM_BITS - 1 - k)),
      .in_vld(div_v[k]), .d(div_d[k]),
      .out_vld(div_v[k+1]), .q(div_d[k+1])
    );
  end

  // Stages 0 to 2: products, dot product, radicand.
  always_comb begin
    logic signed [19:0] acc;
    logic signed [39:0] csq;
    logic signed [17:0] bl;
    st_nxt[0] = '0;
    st_nxt[0].a = {in_a_z, in_a_y, in_a_x, in_a_w};
    st_nxt[0].b = {in_b_z, in_b_y, in_b_x, in_b_w};
    bl = $signed(in_blend);
    if (bl < 0) begin
      st_nxt[0].t = '0;
    end else if (bl > $signed({1'b0, BLEND_ONE})) begin
      st_nxt[0].t = BLEND_ONE;
    end else begin
      st_nxt[0].t = bl[16:0];
    end
    for (int i = 0; i < 4; i++) begin
      st_nxt[0].prod[i] = 32'($signed(st_nxt[0].a[i]) * $signed(st_nxt[0].b[i]));
    end

    st_nxt[1] = st_r[0];
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      acc = acc + 20'($signed(st_r[0].prod[i]) >>> FB);
    end
    st_nxt[1].c = acc;

    st_nxt[2] = st_r[1];
    csq = $signed(st_r[1].c) * $signed(st_r[1].c);
    st_nxt[2].n = 29'(40'(1) << (2 * FB)) - 29'(csq);
    st_nxt[2].par = ($signed(st_r[1].c) >= $signed({5'b0, ONE_Q}))
                 || ($signed(st_r[1].c) <= -$signed({5'b0, ONE_Q}));
    st_nxt[2].sh = '0;
  end

  // Stage 3: sine test and vectoring setup; stages 4 to 6: angles.
  always_comb begin
    logic signed [19:0] cabs;
    logic signed [18:0] th;
    logic [33:0]        pa;
    logic [33:0]        pb;
    logic [16:0]        ga;
    logic [16:0]        gb;
    st_nxt[3] = root_d[ROOT_BITS];
    st_nxt[3].low = root_d[ROOT_BITS].sh <= LOW_SINE_MAX;
    cabs = $signed(root_d[ROOT_BITS].c);
    if (cabs < 0) begin
      cabs = -cabs;
    end
    st_nxt[3].vec.x = cabs;
    st_nxt[3].vec.y = $signed({5'b0, root_d[ROOT_BITS].sh});
    st_nxt[3].vec.z = '0;

    st_nxt[4] = vec_d[IT];
    if ($signed(vec_d[IT].c) >= 0) begin
      th = 19'(vec_d[IT].vec.z);
    end else begin
      th = $signed({2'b0, PI_Q}) - 19'(vec_d[IT].vec.z);
    end
    if (th < 0) begin
      st_nxt[4].th = '0;
    end else if (th > $signed({2'b0, PI_Q})) begin
      st_nxt[4].th = PI_Q;
    end else begin
      st_nxt[4].th = th[16:0];
    end

    st_nxt[5] = st_r[4];
    pa = 34'(BLEND_ONE - st_r[4].t) * 34'(st_r[4].th);
    pb = 34'(st_r[4].t) * 34'(st_r[4].th);
    st_nxt[5].ang_a = pa[32:16];
    st_nxt[5].ang_b = pb[32:16];

    st_nxt[6] = st_r[5];
    ga = (st_r[5].ang_a > HALF_PI_Q) ? PI_Q - st_r[5].ang_a : st_r[5].ang_a;
    gb = (st_r[5].ang_b > HALF_PI_Q) ? PI_Q - st_r[5].ang_b : st_r[5].ang_b;
    st_nxt[6].rota.x = GAIN_Q;
    st_nxt[6].rota.y = '0;
    st_nxt[6].rota.z = $signed({1'b0, ga});
    st_nxt[6].rotb.x = GAIN_Q;
    st_nxt[6].rotb.y = '0;
    st_nxt[6].rotb.z = $signed({1'b0, gb});
  end

  // Stages 7 to 10: divider setup, ratio limit, scaling, blend and select.
  always_comb begin
    logic [14:0]        sa;
    logic [14:0]        sb;
    logic signed [27:0] ph;
    logic signed [30:0] pl;
    logic signed [28:0] sum;
    logic signed [16:0] mid;
    st_nxt[7] = rot_d[IT];
    if (rot_d[IT].rota.y < 0) begin
      sa = '0;
    end else if (rot_d[IT].rota.y > $signed({5'b0, ONE_Q})) begin
      sa = ONE_Q;
    end else begin
      sa = rot_d[IT].rota.y[14:0];
    end
    if (rot_d[IT].rotb.y < 0) begin
      sb = '0;
    end else if (rot_d[IT].rotb.y > $signed({5'b0, ONE_Q})) begin
      sb = ONE_Q;
    end else begin
      sb = rot_d[IT].rotb.y[14:0];
    end
    st_nxt[7].na = {sa, {FB{1'b0}}};
    st_nxt[7].nb = {sb, {FB{1'b0}}};
    st_nxt[7].rma = '0;
    st_nxt[7].rmb = '0;
    st_nxt[7].qa = '0;
    st_nxt[7].qb = '0;

    st_nxt[8] = div_d[NUM_BITS];
    st_nxt[8].ra = (div_d[NUM_BITS].qa > 29'(RATIO_MAX)) ? RATIO_MAX
                 : div_d[NUM_BITS].qa[24:0];
    st_nxt[8].rb = (div_d[NUM_BITS].qb > 29'(RATIO_MAX)) ? RATIO_MAX
                 : div_d[NUM_BITS].qb[24:0];

    st_nxt[9] = st_r[8];
    for (int i = 0; i < 4; i++) begin
      ph = $signed(st_r[8].a[i]) * $signed({1'b0, st_r[8].ra[24:FB]});
      pl = $signed(st_r[8].a[i]) * $signed({1'b0, st_r[8].ra[FB-1:0]});
      st_nxt[9].ta[i] = ph + 28'(pl >>> FB);
      ph = $signed(st_r[8].b[i]) * $signed({1'b0, st_r[8].rb[24:FB]});
      pl = $signed(st_r[8].b[i]) * $signed({1'b0, st_r[8].rb[FB-1:0]});
      st_nxt[9].tb[i] = ph + 28'(pl >>> FB);
    end

    st_nxt[10] = st_r[9];
    for (int i = 0; i < 4; i++) begin
      sum = 29'($signed(st_r[9].ta[i])) + 29'($signed(st_r[9].tb[i]));
      mid = (17'($signed(st_r[9].a[i])) + 17'($signed(st_r[9].b[i]))) >>> 1;
      if (st_r[9].par) begin
        st_nxt[10].r[i] = st_r[9].a[i];
      end else if (st_r[9].low) begin
        st_nxt[10].r[i] = mid[15:0];
      end else begin
        st_nxt[10].r[i] = sat16(sum);
      end
    end
    if (st_r[9].par) begin
      st_nxt[10].path = PATH_FIRST;
    end else if (st_r[9].low) begin
      st_nxt[10].path = PATH_MID;
    end else begin
      st_nxt[10].path = PATH_SLERP;
    end
  end

  assign sv_nxt = {sv_r[9], sv_r[8], div_v[NUM_BITS], rot_v[IT], sv_r[5], sv_r[4],
                   vec_v[IT], root_v[ROOT_BITS], sv_r[1], sv_r[0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (en) begin
      sv_r <= sv_nxt;
    end
    if (en) begin
      for (int k = 0; k < NST; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_valid = sv_r[NST-1];
  assign out_r_w = st_r[NST-1].r[0];
  assign out_r_x = st_r[NST-1].r[1];
  assign out_r_y = st_r[NST-1].r[2];
  assign out_r_z = st_r[NST-1].r[3];
  assign out_path = st_r[NST-1].path;

  // The square root chain leaves the floor of the root of the radicand.
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r[3] && !st_r[3].par |->
      ({15'b0, st_r[3].sh} * {15'b0, st_r[3].sh}) <= {1'b0, st_r[3].n})
    else $error("square root result too large");

  a_root_tight: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r[3] && !st_r[3].par |->
      ({16'b0, 16'(st_r[3].sh) + 16'd1} * {16'b0, 16'(st_r[3].sh) + 16'd1})
        > {3'b0, st_r[3].n})
    else $error("square root result too small");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r[8] && !st_r[8].par && !st_r[8].low |->
      (44'(st_r[8].qa) * 44'(st_r[8].sh)) <= 44'(st_r[8].na))
    else $error("blend ratio quotient too large");

  a_first_path: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r[NST-1] && st_r[NST-1].path == PATH_FIRST |-> st_r[NST-1].r == st_r[NST-1].a)
    else $error("first-input path altered the components");

endmodule

`default_nettype wire

/* bench/tb_quaternion_slerp.sv */
// ----------------------------------------------------------------------------
// Quaternion slerp testbench
// Drives quaternion pairs with blend fractions into the slerp pipe, predicts
// each result in fixed point and compares every returned field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quaternion_slerp;
  import qslerp_pkg::*;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [1:0]  path;
  } slerp_res_t;

  localparam longint CYCLE_LIMIT = 2000000;
  localparam int PIPE_DEPTH = 87;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_a_w, in_a_x, in_a_y, in_a_z;
  logic [15:0] in_b_w, in_b_x, in_b_y, in_b_z;
  logic [17:0] in_blend;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_r_w, out_r_x, out_r_y, out_r_z;
  logic [1:0]  out_path;

  slerp_res_t expected_q[$];
  int         error_count;
  longint     cycle_count = 0;
  int         stall_left = 0;

  quaternion_slerp u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a_w(in_a_w), .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_w(in_b_w), .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .in_blend(in_blend),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_r_w(out_r_w), .out_r_x(out_r_x), .out_r_y(out_r_y), .out_r_z(out_r_z),
    .out_path(out_path)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(int i);
    longint v;
    v = longint'(ATAN_Q30[i]);
    return v >> (30 - FB);
  endfunction

  function automatic longint int_root(longint n);
    longint res;
    longint bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint half_angle(longint xv, longint yv);
    longint zv, dx, dy;
    zv = 0;
    for (int i = 0; i < IT; i++) begin
      dx = floor_shr(yv, i);
      dy = floor_shr(xv, i);
      if (yv >= 0) begin
        xv = xv + dx; yv = yv - dy; zv = zv + atan_step(i);
      end else begin
        xv = xv - dx; yv = yv + dy; zv = zv - atan_step(i);
      end
    end
    return zv;
  endfunction

  function automatic longint sine_of(longint ang);
    longint xv, yv, dx, dy;
    xv = longint'(GAIN_Q30) >> (30 - FB);
    yv = 0;
    for (int i = 0; i < IT; i++) begin
      dx = floor_shr(yv, i);
      dy = floor_shr(xv, i);
      if (ang >= 0) begin
        xv = xv - dx; yv = yv + dy; ang = ang - atan_step(i);
      end else begin
        xv = xv + dx; yv = yv - dy; ang = ang + atan_step(i);
      end
    end
    return yv;
  endfunction

  function automatic longint weight_of(longint ang, longint sh);
    longint one, pi_q, hp_q, s, r;
    one = longint'(1) << FB;
    pi_q = longint'(PI_Q30) >> (30 - FB);
    hp_q = longint'(HALF_PI_Q30) >> (30 - FB);
    if (ang > hp_q) ang = pi_q - ang;
    if (ang < 0) ang = 0;
    s = sine_of(ang);
    if (s < 0) s = 0;
    if (s > one) s = one;
    r = (s << FB) / sh;
    if (r > 1024 * one) r = 1024 * one;
    return r;
  endfunction

  function automatic longint weighted(longint a, longint r);
    longint one;
    one = longint'(1) << FB;
    return a * (r >> FB) + floor_shr(a * (r & (one - 1)), FB);
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic slerp_res_t predict_slerp(logic [3:0][15:0] qa, logic [3:0][15:0] qb,
                                               logic [17:0] blend);
    slerp_res_t res;
    longint a[4], b[4], r[4];
    longint one, c, t, sh, th, ra, rb, pi_q;
    logic [1:0] p;
    one = longint'(1) << FB;
    pi_q = longint'(PI_Q30) >> (30 - FB);
    c = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'($signed(qa[i]));
      b[i] = longint'($signed(qb[i]));
      c = c + floor_shr(a[i] * b[i], FB);
    end
    t = longint'($signed(blend));
    if (t < 0) t = 0;
    if (t > 65536) t = 65536;
    if (c >= one || c <= -one) begin
      p = PATH_FIRST;
      for (int i = 0; i < 4; i++) r[i] = a[i];
    end else begin
      sh = int_root(one * one - c * c);
      if (sh * 1000 < one) begin
        p = PATH_MID;
        for (int i = 0; i < 4; i++) r[i] = clip16(floor_shr(a[i] + b[i], 1));
      end else begin
        if (c >= 0) th = half_angle(c, sh);
        else th = pi_q - half_angle(-c, sh);
        if (th < 0) th = 0;
        if (th > pi_q) th = pi_q;
        ra = weight_of(((65536 - t) * th) >>> 16, sh);
        rb = weight_of((t * th) >>> 16, sh);
        p = PATH_SLERP;
        for (int i = 0; i < 4; i++) r[i] = clip16(weighted(a[i], ra) + weighted(b[i], rb));
      end
    end
    res.w = r[0][15:0];
    res.x = r[1][15:0];
    res.y = r[2][15:0];
    res.z = r[3][15:0];
    res.path = p;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("tb: mismatch %s got %h expected %h", what, got, want);
    error_count++;
  endtask

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Sends one request and records the predicted result once it is taken.
  task automatic send_request(logic [3:0][15:0] qa, logic [3:0][15:0] qb, logic [17:0] blend);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_a_w <= qa[0]; in_a_x <= qa[1]; in_a_y <= qa[2]; in_a_z <= qa[3];
    in_b_w <= qb[0]; in_b_x <= qb[1]; in_b_y <= qb[2]; in_b_z <= qb[3];
    in_blend <= blend;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(predict_slerp(qa, qb, blend));
  endtask

  // A random unit-ish quaternion with a little noise on its length.
  function automatic logic [3:0][15:0] unit_quat();
    logic [3:0][15:0] q;
    real v[4];
    real n;
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      v[i] = real'(int'($urandom_range(0, 2000)) - 1000);
      n += v[i] * v[i];
    end
    if (n < 1.0) n = 1.0;
    n = $sqrt(n);
    for (int i = 0; i < 4; i++) q[i] = 16'(int'(v[i] / n * 16384.0));
    return q;
  endfunction

  function automatic logic [17:0] rand_blend();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 18'($urandom);
    if (k == 1) return (k == 1 && $urandom_range(0, 1)) ? 18'd0 : 18'd65536;
    return 18'($urandom_range(0, 65536));
  endfunction

  task automatic test_directed();
    logic [3:0][15:0] qa, qb, qn;
    qa = {16'd0, 16'd0, 16'd0, 16'd16384};
    send_request(qa, qa, 18'd32768);
    qn = {16'd0, 16'd0, 16'd0, -16'sd16384};
    send_request(qa, qn, 18'd32768);
    qb = {16'd0, 16'd0, 16'd16384, 16'd0};
    send_request(qa, qb, 18'd0);
    send_request(qa, qb, 18'd65536);
    send_request(qa, qb, 18'h20000);
    send_request(qa, qb, 18'h1FFFF);
    send_request(qa, qb, 18'd16384);
    qb = {16'd0, 16'd0, 16'd1, -16'sd16383};
    send_request(qa, qb, 18'd32768);
    qb = {16'd0, 16'd0, 16'd11585, -16'sd11585};
    send_request(qa, qb, 18'd40000);
    qa = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
    qb = {16'h8000, 16'h8000, 16'h8000, 16'h8000};
    send_request(qa, qb, 18'd1);
    send_request(qb, qb, 18'd1);
    qa = {16'h0000, 16'h0000, 16'h0000, 16'h0100};
    qb = {16'h0000, 16'h0000, 16'h0100, 16'h0000};
    send_request(qa, qb, 18'd30000);
    qa = {16'h0000, 16'h0000, 16'h7FFF, 16'h0000};
    qb = {16'h0000, 16'h8000, 16'h0000, 16'h0000};
    send_request(qa, qb, 18'd65535);
  endtask

  task automatic test_random();
    logic [3:0][15:0] qa, qb;
    int k;
    for (int n = 0; n < 1900; n++) begin
      k = $urandom_range(0, 99);
      qa = unit_quat();
      if (k < 60) begin
        qb = unit_quat();
      end else if (k < 70) begin
        qb = qa;
        qb[$urandom_range(0, 3)] += 16'($urandom_range(0, 4) - 2);
      end else if (k < 80) begin
        for (int i = 0; i < 4; i++) qb[i] = -qa[i] + 16'($urandom_range(0, 2) - 1);
      end else if (k < 90) begin
        for (int i = 0; i < 4; i++) qa[i] = 16'($urandom);
        for (int i = 0; i < 4; i++) qb[i] = 16'($urandom);
      end else begin
        qb = unit_quat();
        for (int i = 0; i < 4; i++) qa[i] = 16'($signed(qa[i]) >>> $urandom_range(0, 6));
      end
      send_request(qa, qb, rand_blend());
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 20) @(posedge clk);
  endtask

  // Receiver stall pattern: alternating stretches of random length, with
  // stretches of no stalling at all.
  always @(posedge clk) begin
    if (!rst_n || (cycle_count % 5000) < 800) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= !out_stall;
      stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    slerp_res_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("tb: unexpected result");
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_r_w !== want.w) report_mismatch("r_w", out_r_w, want.w);
        if (out_r_x !== want.x) report_mismatch("r_x", out_r_x, want.x);
        if (out_r_y !== want.y) report_mismatch("r_y", out_r_y, want.y);
        if (out_r_z !== want.z) report_mismatch("r_z", out_r_z, want.z);
        if (out_path !== want.path) report_mismatch("path", 16'(out_path), 16'(want.path));
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    {in_a_w, in_a_x, in_a_y, in_a_z} = '0;
    {in_b_w, in_b_x, in_b_y, in_b_z} = '0;
    in_blend = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    wait_drain();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
